[src/kalman_angle_bias_filter_unit_macros.svh]
// Assertion macros for the Kalman angle/bias filter.
// No dependencies; included by the top level.
`ifndef KALMAN_ANGLE_BIAS_FILTER_UNIT_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define KABF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KABF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KABF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KABF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/kabf_pkg.sv]
// Shared types, constants and saturation helper for the Kalman filter.
// No dependencies.
package kabf_pkg;
    localparam int CFG_IDX_W = 4;
    localparam int NOISE_W   = 24;
    localparam int DT_W      = 16;
    localparam int DIV_STEPS = 56;

    typedef logic signed [31:0] q32_t;
    typedef logic [NOISE_W-1:0] noise_t;
    typedef logic [DT_W-1:0]    dt_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_NOISE_ANGLE = 4'd0;
    localparam cfg_idx_t CFG_NOISE_BIAS  = 4'd1;
    localparam cfg_idx_t CFG_NOISE_MEAS  = 4'd2;
    localparam cfg_idx_t CFG_START_ANGLE = 4'd3;

    localparam noise_t RST_NOISE_ANGLE = 24'd16777;
    localparam noise_t RST_NOISE_BIAS  = 24'd50332;
    localparam noise_t RST_NOISE_MEAS  = 24'd503316;

    function automatic q32_t sat32(input logic signed [71:0] x);
        q32_t r;
        if (x > 72'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -72'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction
endpackage

[src/kabf_if.sv]
// Valid/ready channel interfaces: sample in, result out, config write.
// Depends on kabf_pkg.
interface kabf_in_if;
    import kabf_pkg::*;
    logic  valid;
    logic  ready;
    q32_t  measured_angle;
    q32_t  gyro_rate;
    dt_t   time_step;
    modport source (output valid, measured_angle, gyro_rate, time_step, input ready);
    modport sink   (input valid, measured_angle, gyro_rate, time_step, output ready);
endinterface

interface kabf_out_if;
    import kabf_pkg::*;
    logic  valid;
    logic  ready;
    q32_t  filtered_angle;
    q32_t  corrected_rate;
    modport source (output valid, filtered_angle, corrected_rate, input ready);
    modport sink   (input valid, filtered_angle, corrected_rate, output ready);
endinterface

interface kabf_cfg_if;
    import kabf_pkg::*;
    logic        valid;
    logic        ready;
    cfg_idx_t    index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/kalman_angle_bias_filter_unit.sv]
// Two-state Kalman filter (angle + gyro bias) built around one shared multiplier.
// Depends on kabf_pkg, kabf_if.sv and kalman_angle_bias_filter_unit_macros.svh.
//
//  channel  | dir | payload                                   | transaction when
//  sample   | in  | measured_angle, gyro_rate, time_step      | valid & ready
//  result   | out | filtered_angle, corrected_rate            | valid & ready
//  cfg      | in  | index (0..3 used), data                   | valid & ready
//
// Each sample runs, from acceptance to the next acceptance: a rate correction and four
// multiply/accumulate pairs, a gate, two gain divisions (restoring, one quotient bit per
// cycle), 12 update steps, the output hand-off and a return to the idle state.
// When the innovation covariance is not positive the divisions are skipped.
// sample.ready and cfg.ready are high only while the sequencer is idle. A finished result
// sits in an output register, so a new sample is taken while the result waits; the
// sequencer stalls at its last step only if a previous result is still unread.
// rst_n clears the state, the covariance and the noise settings to defaults.
`include "kalman_angle_bias_filter_unit_macros.svh"
module kalman_angle_bias_filter_unit (
    input  logic             clk,
    input  logic             rst_n,
    kabf_in_if.sink          sample,
    kabf_out_if.source       result,
    kabf_cfg_if.sink         cfg
);
    import kabf_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0,  ST_CORR = 5'd1,  ST_M1 = 5'd2,  ST_A1 = 5'd3,
                           ST_M2 = 5'd4,  ST_A2 = 5'd5,  ST_M3 = 5'd6,  ST_A3 = 5'd7,
                           ST_M4 = 5'd8,  ST_A4 = 5'd9,  ST_GATE = 5'd10, ST_DSET = 5'd11,
                           ST_DIV = 5'd12, ST_DEND = 5'd13, ST_M5 = 5'd14, ST_A5 = 5'd15,
                           ST_M6 = 5'd16, ST_A6 = 5'd17, ST_M7 = 5'd18, ST_A7 = 5'd19,
                           ST_M8 = 5'd20, ST_A8 = 5'd21, ST_M9 = 5'd22, ST_A9 = 5'd23,
                           ST_M10 = 5'd24, ST_A10 = 5'd25, ST_DONE = 5'd26;

    logic [4:0] state_reg, state_next;

    // settings
    noise_t qa_reg, qb_reg, r_reg;

    // filter state
    q32_t angle_reg, bias_reg, paa_reg, pab_reg, pba_reg, pbb_reg;

    // per-sample working registers
    q32_t                meas_reg, rate_reg, corr_reg, y_reg, k0_reg, k1_reg;
    dt_t                 dt_reg;
    logic signed [32:0]  t_reg;
    logic signed [33:0]  s_reg;
    logic signed [67:0]  prod_reg;

    // divider
    logic [32:0]         rem_reg;
    logic [DIV_STEPS-1:0] dq_reg;
    logic [5:0]          cnt_reg;
    logic                neg_reg;
    logic                sel_reg;

    // output register
    logic out_valid_reg;
    q32_t filt_out_reg, corr_out_reg;

    // shared multiplier operands
    logic signed [32:0]  mul_a;
    logic signed [34:0]  mul_b;
    logic signed [32:0]  dt_ext;
    logic signed [34:0]  inner;
    logic signed [67:0]  r16, r24;

    // divider datapath
    logic [33:0]         trial;
    logic                ge;
    q32_t                num;
    logic signed [32:0]  num_abs;
    logic signed [71:0]  q_signed;
    logic                s_pos;

    assign dt_ext = signed'({17'b0, dt_reg});
    assign inner  = 35'(t_reg) - 35'(pab_reg) - 35'(pba_reg) + signed'({11'b0, qa_reg});
    assign r16    = (prod_reg + 68'sd32768) >>> 16;
    assign r24    = (prod_reg + 68'sd8388608) >>> 24;

    assign trial    = {rem_reg, dq_reg[DIV_STEPS-1]};
    assign ge       = trial >= {1'b0, s_reg[32:0]};
    assign num      = sel_reg ? pba_reg : paa_reg;
    assign num_abs  = num[31] ? -(33'(num)) : 33'(num);
    assign q_signed = signed'({16'b0, dq_reg});
    assign s_pos    = !s_reg[33] && (s_reg != 34'sd0);

    assign sample.ready         = (state_reg == ST_IDLE);
    assign cfg.ready            = (state_reg == ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.filtered_angle = filt_out_reg;
    assign result.corrected_rate = corr_out_reg;

    // operand select for the one multiplier
    always_comb
    begin
        mul_a = dt_ext;
        mul_b = 35'(corr_reg);
        case (state_reg)
            ST_M1:  mul_b = 35'(corr_reg);
            ST_M2:  mul_b = 35'(pbb_reg);
            ST_M3:  mul_b = inner;
            ST_M4:  mul_b = signed'({11'b0, qb_reg});
            ST_M5:  begin mul_a = 33'(k0_reg); mul_b = 35'(y_reg);   end
            ST_M6:  begin mul_a = 33'(k1_reg); mul_b = 35'(y_reg);   end
            ST_M7:  begin mul_a = 33'(k1_reg); mul_b = 35'(paa_reg); end
            ST_M8:  begin mul_a = 33'(k1_reg); mul_b = 35'(pab_reg); end
            ST_M9:  begin mul_a = 33'(k0_reg); mul_b = 35'(paa_reg); end
            ST_M10: begin mul_a = 33'(k0_reg); mul_b = 35'(pab_reg); end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (sample.valid) state_next = ST_CORR;
            ST_GATE: state_next = s_pos ? ST_DSET : ST_M5;
            ST_DIV:  if (cnt_reg == 6'(DIV_STEPS - 1)) state_next = ST_DEND;
            ST_DEND: state_next = sel_reg ? ST_M5 : ST_DSET;
            ST_DONE: if (!out_valid_reg || result.ready) state_next = ST_IDLE;
            default: state_next = state_reg + 5'd1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            qa_reg        <= RST_NOISE_ANGLE;
            qb_reg        <= RST_NOISE_BIAS;
            r_reg         <= RST_NOISE_MEAS;
            angle_reg     <= '0;
            bias_reg      <= '0;
            paa_reg       <= '0;
            pab_reg       <= '0;
            pba_reg       <= '0;
            pbb_reg       <= '0;
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // load a finished result, or drop the one just read
            if (state_reg == ST_DONE && (!out_valid_reg || result.ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_NOISE_ANGLE: qa_reg <= cfg.data[NOISE_W-1:0];
                    CFG_NOISE_BIAS:  qb_reg <= cfg.data[NOISE_W-1:0];
                    CFG_NOISE_MEAS:  r_reg  <= cfg.data[NOISE_W-1:0];
                    CFG_START_ANGLE: angle_reg <= cfg.data;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_A1: angle_reg <= sat32(72'(angle_reg) + 72'(r16));
                ST_A3:
                begin
                    paa_reg <= sat32(72'(paa_reg) + 72'(r16));
                    pab_reg <= sat32(72'(pab_reg) - 72'(t_reg));
                    pba_reg <= sat32(72'(pba_reg) - 72'(t_reg));
                end
                ST_A4:  pbb_reg <= sat32(72'(pbb_reg) + 72'(r16));
                ST_GATE: sel_reg <= 1'b0;
                ST_DSET: cnt_reg <= '0;
                ST_DIV:  cnt_reg <= cnt_reg + 6'd1;
                ST_DEND: sel_reg <= 1'b1;
                ST_A5:  angle_reg <= sat32(72'(angle_reg) + 72'(r24));
                ST_A6:  bias_reg  <= sat32(72'(bias_reg) + 72'(r24));
                ST_A7:  pba_reg   <= sat32(72'(pba_reg) - 72'(r24));
                ST_A8:  pbb_reg   <= sat32(72'(pbb_reg) - 72'(r24));
                ST_A9:  paa_reg   <= sat32(72'(paa_reg) - 72'(r24));
                ST_A10: pab_reg   <= sat32(72'(pab_reg) - 72'(r24));
                default: ;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                meas_reg <= sample.measured_angle;
                rate_reg <= sample.gyro_rate;
                dt_reg   <= sample.time_step;
            end
            ST_CORR: corr_reg <= sat32(72'(rate_reg) - 72'(bias_reg));
            ST_A2:   t_reg <= r16[32:0];
            ST_A4:
            begin
                y_reg <= sat32(72'(meas_reg) - 72'(angle_reg));
                s_reg <= 34'(paa_reg) + signed'({10'b0, r_reg});
            end
            ST_GATE:
            begin
                k0_reg <= '0;
                k1_reg <= '0;
            end
            ST_DSET:
            begin
                neg_reg <= num[31];
                rem_reg <= '0;
                dq_reg  <= {num_abs[31:0], 24'b0};
            end
            ST_DIV:
            begin
                rem_reg <= ge ? 33'(trial - {1'b0, s_reg[32:0]}) : trial[32:0];
                dq_reg  <= {dq_reg[DIV_STEPS-2:0], ge};
            end
            ST_DEND:
                if (sel_reg)
                    k1_reg <= sat32(neg_reg ? -q_signed : q_signed);
                else
                    k0_reg <= sat32(neg_reg ? -q_signed : q_signed);
            ST_DONE:
                if (!out_valid_reg || result.ready)
                begin
                    filt_out_reg <= angle_reg;
                    corr_out_reg <= corr_reg;
                end
            default: ;
        endcase
    end

    `KABF_ASSERT_NXT(a_start, clk, rst_n, sample.valid && sample.ready, state_reg == ST_CORR)
    `KABF_ASSERT_IMP(a_div_pos, clk, rst_n, state_reg == ST_DIV, s_pos)
    `KABF_ASSERT_IMP(a_div_cnt, clk, rst_n, state_reg == ST_DIV, cnt_reg < 6'(DIV_STEPS))
    `KABF_ASSERT_NXT(a_done, clk, rst_n, state_reg == ST_DONE && state_next == ST_IDLE, out_valid_reg)
endmodule
